@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the timer table rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ttt_pkg.sv @@
// ----------------------------------------------------------------------------
// ttt_pkg
// types, codes and control store of the tick timer table
// ----------------------------------------------------------------------------
package ttt_pkg;

  // request codes
  typedef enum logic [1:0] {
    ACT_TICK          = 2'd0,
    ACT_ADD           = 2'd1,
    ACT_SET_COUNTDOWN = 2'd2,
    ACT_START_DELAY   = 2'd3
  } action_t;

  // result kinds
  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
    logic [31:0] tag;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [31:0] expired_tag;
    logic        accepted;
    logic [31:0] system_time;
    logic        countdown_running;
    logic        delay_busy;
    logic        last;
  } out_item_t;

  // sequencer step addresses
  typedef enum logic [3:0] {
    S_WAIT      = 4'd0,
    S_TICK      = 4'd1,
    S_TICK_RD   = 4'd2,
    S_TICK_UPD  = 4'd3,
    S_ADD       = 4'd4,
    S_ADD_SCAN  = 4'd5,
    S_SET_CD    = 4'd6,
    S_SET_DL    = 4'd7,
    S_STATUS    = 4'd8
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS       = 3'd0,
    COND_IN_VALID     = 3'd1,
    COND_VALUE_ZERO   = 3'd2,
    COND_LAST_SLOT    = 3'd3,
    COND_FREE_OR_LAST = 3'd4
  } cond_t;

  // one control word
  typedef struct packed {
    logic  take_in;
    logic  dispatch;
    logic  tick_upd;
    logic  idx_clr;
    logic  dec_slot;
    logic  arm_slot;
    logic  load_cd;
    logic  load_dl;
    logic  emit_status;
    logic  inc_on_false;
    cond_t cond;
    step_t on_true;
    step_t on_false;
  } ctrl_t;

  // control store
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c          = '0;
    c.cond     = COND_ALWAYS;
    c.on_true  = S_WAIT;
    c.on_false = S_WAIT;
    case (s)
      S_WAIT: begin
        c.take_in  = 1'b1;
        c.dispatch = 1'b1;
        c.cond     = COND_IN_VALID;
        c.on_false = S_WAIT;
      end
      S_TICK: begin
        c.tick_upd = 1'b1;
        c.idx_clr  = 1'b1;
        c.on_true  = S_TICK_RD;
      end
      S_TICK_RD: begin
        c.on_true = S_TICK_UPD;
      end
      S_TICK_UPD: begin
        c.dec_slot     = 1'b1;
        c.cond         = COND_LAST_SLOT;
        c.on_true      = S_STATUS;
        c.on_false     = S_TICK_RD;
        c.inc_on_false = 1'b1;
      end
      S_ADD: begin
        c.idx_clr  = 1'b1;
        c.cond     = COND_VALUE_ZERO;
        c.on_true  = S_STATUS;
        c.on_false = S_ADD_SCAN;
      end
      S_ADD_SCAN: begin
        c.arm_slot     = 1'b1;
        c.cond         = COND_FREE_OR_LAST;
        c.on_true      = S_STATUS;
        c.on_false     = S_ADD_SCAN;
        c.inc_on_false = 1'b1;
      end
      S_SET_CD: begin
        c.load_cd = 1'b1;
        c.on_true = S_STATUS;
      end
      S_SET_DL: begin
        c.load_dl = 1'b1;
        c.on_true = S_STATUS;
      end
      S_STATUS: begin
        c.emit_status = 1'b1;
        c.on_true     = S_WAIT;
      end
      default: begin
        c.on_true = S_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

@@ rtl/ttt_ram.sv @@
// ----------------------------------------------------------------------------
// ttt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ttt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tick_timer_table.sv @@
// ----------------------------------------------------------------------------
// tick_timer_table
// table of one-shot tick timers with system time, delay and countdown
// ----------------------------------------------------------------------------
// A tick transaction advances the system time, decrements the delay counter
// (which wraps from zero) and the countdown (which stops at zero), then walks
// the slot table and decrements every armed slot; each slot that reaches zero
// sends an expiry result with its index and tag, in slot order, and is freed.
// An add transaction arms the lowest free slot with its timeout and tag; a
// zero timeout or a full table arms nothing. Every transaction ends with one
// status result flagged last. A small microcoded sequencer does the work:
// one item at a time, a ram read step and then an update step per slot on a
// tick, since remaining counts and tags live in registered-read rams. The
// sequencer holds while the output side stalls a result it emits. A finished
// result sits in an output register, so the status of one item may wait
// there while the next item is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tick_timer_table
  import ttt_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // sequencer
  step_t step, step_next;
  ctrl_t uc;
  logic  cond_hit;

  // scalar timers
  logic [31:0] tick_count;
  logic [31:0] delay_left;
  logic [31:0] countdown_left;

  // latched request
  logic [31:0] value_q;
  logic [31:0] tag_q;
  logic        acc_q;
  logic [2:0]  slot_q;

  // slot table: armed bits in flops, counts and tags in ram
  logic [SLOT_COUNT-1:0] armed;
  logic [IDX_W-1:0]      idx;
  logic [31:0]           rem_rd;
  logic [31:0]           tag_rd;
  logic                  rem_we;
  logic [31:0]           rem_wdata;

  // datapath controls
  logic slot_armed;
  logic fire;
  logic arm_go;
  logic emit_any;
  logic stall;
  logic in_fire;

  assign uc         = ucode(step);
  assign slot_armed = armed[idx];
  assign in_ready   = uc.take_in;
  assign in_fire    = in_valid && in_ready;

  // jump condition from the control word
  always_comb begin
    unique case (uc.cond)
      COND_ALWAYS:       cond_hit = 1'b1;
      COND_IN_VALID:     cond_hit = in_valid;
      COND_VALUE_ZERO:   cond_hit = (value_q == 32'd0);
      COND_LAST_SLOT:    cond_hit = (idx == LAST_IDX);
      COND_FREE_OR_LAST: cond_hit = !slot_armed || (idx == LAST_IDX);
      default:           cond_hit = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    step_next = step;
    if (!stall) begin
      if (cond_hit) begin
        if (uc.dispatch) begin
          unique case (action_t'(in_data.action))
            ACT_TICK:          step_next = S_TICK;
            ACT_ADD:           step_next = S_ADD;
            ACT_SET_COUNTDOWN: step_next = S_SET_CD;
            ACT_START_DELAY:   step_next = S_SET_DL;
          endcase
        end else begin
          step_next = uc.on_true;
        end
      end else begin
        step_next = uc.on_false;
      end
    end
  end

  // datapath strobes
  always_comb begin
    fire      = uc.dec_slot && slot_armed && (rem_rd == 32'd1);
    emit_any  = uc.emit_status || fire;
    stall     = emit_any && out_valid && !out_ready;
    arm_go    = uc.arm_slot && !slot_armed;
    rem_we    = !stall && ((uc.dec_slot && slot_armed) || arm_go);
    rem_wdata = arm_go ? value_q : (rem_rd - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // slot index walks the table
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (!stall) begin
      if (uc.idx_clr) begin
        idx <= '0;
      end else if (!cond_hit && uc.inc_on_false) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // system time, delay and countdown
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      delay_left     <= '0;
      countdown_left <= '0;
    end else begin
      if (uc.tick_upd) begin
        tick_count <= tick_count + 32'd1;
        delay_left <= delay_left - 32'd1;
        if (countdown_left != 32'd0) begin
          countdown_left <= countdown_left - 32'd1;
        end
      end
      if (uc.load_cd) begin
        countdown_left <= value_q;
      end
      if (uc.load_dl) begin
        delay_left <= value_q;
      end
    end
  end

  // request latch and add outcome
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_q <= in_data.value;
      tag_q   <= in_data.tag;
      acc_q   <= 1'b0;
      slot_q  <= 3'd0;
    end else if (arm_go) begin
      acc_q  <= 1'b1;
      slot_q <= 3'(idx);
    end
  end

  // armed bits: set on add, cleared when a slot expires
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else if (!stall) begin
      if (arm_go) begin
        armed[idx] <= 1'b1;
      end else if (fire) begin
        armed[idx] <= 1'b0;
      end
    end
  end

  ttt_ram #(
    .WIDTH (32),
    .DEPTH (SLOT_COUNT)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (idx),
    .wdata (rem_wdata),
    .raddr (idx),
    .rdata (rem_rd)
  );

  ttt_ram #(
    .WIDTH (32),
    .DEPTH (SLOT_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (arm_go),
    .waddr (idx),
    .wdata (tag_q),
    .raddr (idx),
    .rdata (tag_rd)
  );

  // output register: expiry or status transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any && !stall) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any && !stall) begin
      out_data.kind              <= uc.emit_status ? KIND_STATUS : KIND_EXPIRY;
      out_data.slot              <= uc.emit_status ? slot_q : 3'(idx);
      out_data.expired_tag       <= uc.emit_status ? 32'd0 : tag_rd;
      out_data.accepted          <= uc.emit_status ? acc_q : 1'b0;
      out_data.system_time       <= tick_count;
      out_data.countdown_running <= (countdown_left != 32'd0);
      out_data.delay_busy        <= (delay_left != 32'd0);
      out_data.last              <= uc.emit_status;
    end
  end

  // an armed slot always holds a nonzero count
  `ASSERT_CLK(a_armed_nonzero, clk, rst,
    (step == S_TICK_UPD && slot_armed) |-> (rem_rd != 32'd0), "armed slot with zero count")
  // a successful add leaves that slot armed
  `ASSERT_CLK(a_add_arms, clk, rst,
    (arm_go && !stall) |=> armed[$past(idx)], "add did not arm its slot")
  // a taken item moves the sequencer out of the wait step
  `ASSERT_CLK(a_take_leaves_wait, clk, rst,
    in_fire |=> (step != S_WAIT), "sequencer stayed in wait after taking an item")
  // reset returns the sequencer to wait with nothing pending
  `ASSERT_CLK_ALWAYS(a_reset_state, clk,
    rst |=> (step == S_WAIT && !out_valid && armed == '0), "bad state after reset")

endmodule

@@ tb/sv/timer_table_checker.sv @@
// ----------------------------------------------------------------------------
// timer_table_checker
// watches both channels of the tick timer table, predicts and compares
// ----------------------------------------------------------------------------
// Every accepted request runs through a private copy of the timer table and
// queues the results it should cause. Every accepted result is compared field
// by field with the oldest queued one.
// ----------------------------------------------------------------------------
module timer_table_checker
  import ttt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        error_count,
  output int        pending_count
);

  // shadow state of the table
  logic [31:0] sys_time;
  logic [31:0] delay_cnt;
  logic [31:0] cd_cnt;
  logic [31:0] slot_left [SLOTS];
  logic [31:0] slot_tag  [SLOTS];

  out_item_t timer_results_due [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  // result with the state as it stands now
  function automatic out_item_t status_word(logic kind, logic [2:0] slot, logic [31:0] tag,
                                            logic acc, logic fin);
    out_item_t r;
    r.kind              = kind;
    r.slot              = slot;
    r.expired_tag       = tag;
    r.accepted          = acc;
    r.system_time       = sys_time;
    r.countdown_running = (cd_cnt != 0);
    r.delay_busy        = (delay_cnt != 0);
    r.last              = fin;
    return r;
  endfunction

  task automatic run_timer_request(in_item_t req);
    logic [2:0]       armed;
    logic             took;
    logic [SLOTS-1:0] fired;
    armed = '0;
    took  = 1'b0;
    fired = '0;
    case (action_t'(req.action))
      ACT_TICK: begin
        sys_time  = sys_time + 1;
        delay_cnt = delay_cnt - 1;
        if (cd_cnt != 0) cd_cnt = cd_cnt - 1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_left[i] != 0) begin
            slot_left[i] = slot_left[i] - 1;
            if (slot_left[i] == 0) fired[i] = 1'b1;
          end
        end
        // expiries go out in slot order, after the whole tick
        for (int i = 0; i < SLOTS; i++) begin
          if (fired[i])
            timer_results_due.push_back(status_word(KIND_EXPIRY, i[2:0], slot_tag[i],
                                                    1'b0, 1'b0));
        end
      end
      ACT_ADD: begin
        if (req.value != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!took && slot_left[i] == 0) begin
              slot_left[i] = req.value;
              slot_tag[i]  = req.tag;
              armed        = i[2:0];
              took         = 1'b1;
            end
          end
        end
      end
      ACT_SET_COUNTDOWN: begin
        cd_cnt = req.value;
      end
      default: begin
        delay_cnt = req.value;
      end
    endcase
    timer_results_due.push_back(status_word(KIND_STATUS, armed, 32'd0, took, 1'b1));
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sys_time  = '0;
      delay_cnt = '0;
      cd_cnt    = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_left[i] = '0;
        slot_tag[i]  = '0;
      end
      timer_results_due.delete();
    end else begin
      if (in_valid && in_ready) run_timer_request(in_data);
      if (out_valid && out_ready) begin
        if (timer_results_due.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, out_data);
          error_count++;
        end else begin
          out_item_t want;
          want = timer_results_due.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("slot", want.slot, out_data.slot);
          check_field("expired_tag", want.expired_tag, out_data.expired_tag);
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("system_time", want.system_time, out_data.system_time);
          check_field("countdown_running", want.countdown_running,
                      out_data.countdown_running);
          check_field("delay_busy", want.delay_busy, out_data.delay_busy);
          check_field("last", want.last, out_data.last);
        end
      end
    end
    pending_count <= timer_results_due.size();
  end

endmodule

@@ tb/sv/tb_tick_timer_table.sv @@
// ----------------------------------------------------------------------------
// tb_tick_timer_table
// testbench of the tick timer table
// ----------------------------------------------------------------------------
// Drives tick, add, set countdown and start delay transactions: a directed
// opening over the corner cases, then a random mix with short timeouts so
// that slots expire, collide and fill the table. Both sides idle at random.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tick_timer_table;
  import ttt_pkg::*;

  localparam int SLOTS       = 8;
  localparam int RAND_ITEMS  = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 3 * (2 * SLOTS + 3);

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int error_count;
  int pending_count;
  int cycle_count = 0;

  // receiver stall state
  int rx_hold   = 0;
  int rx_roll;
  bit rx_steady = 1'b0;

  // sender gap state
  bit tx_steady = 1'b0;

  tick_timer_table #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  timer_table_checker #(
    .SLOTS(SLOTS)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a hung block or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tick_timer_table failed");
      $finish;
    end
  end

  // result side: mostly ready, short stalls, now and then a long one,
  // and stretches with no stall at all
  always @(posedge clk) begin
    if (cycle_count % 256 == 0) rx_steady <= ($urandom_range(0, 3) == 0);
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_steady || rx_roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_hold   <= (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // one request transaction; valid stays up across back-to-back requests
  task automatic issue_request(action_t act, logic [31:0] val, logic [31:0] tag);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.action <= act;
    in_data.value  <= val;
    in_data.tag    <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int roll;
    logic [31:0] val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed opening ---
    // tick on an idle table: time advances, delay wraps from zero
    issue_request(ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero timeout arms nothing
    issue_request(ACT_ADD, 32'd0, 32'h0000_DEAD);
    // fill the whole table with the same short timeout
    issue_request(ACT_ADD, 32'd2, 32'h0000_0000);
    issue_request(ACT_ADD, 32'd2, 32'hFFFF_FFFF);
    issue_request(ACT_ADD, 32'd2, 32'hAAAA_AAAA);
    issue_request(ACT_ADD, 32'd2, 32'h5555_5555);
    issue_request(ACT_ADD, 32'd2, 32'h8000_0001);
    issue_request(ACT_ADD, 32'd2, 32'h0F0F_F0F0);
    issue_request(ACT_ADD, 32'd2, 32'h1234_5678);
    issue_request(ACT_ADD, 32'd2, 32'hCAFE_0007);
    // table full
    issue_request(ACT_ADD, 32'd3, 32'h7777_7777);
    issue_request(ACT_SET_COUNTDOWN, 32'hFFFF_FFFF, 32'd0);
    issue_request(ACT_SET_COUNTDOWN, 32'd2, 32'd0);
    issue_request(ACT_START_DELAY, 32'd0, 32'd0);
    issue_request(ACT_TICK, 32'd0, 32'd0);
    // every slot fires on the same tick, countdown reaches zero
    issue_request(ACT_TICK, 32'd0, 32'd0);
    // stopped countdown holds at zero
    issue_request(ACT_TICK, 32'd0, 32'd0);
    issue_request(ACT_START_DELAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(ACT_ADD, 32'd1, 32'h0000_0000);
    issue_request(ACT_ADD, 32'd3, 32'hFFFF_FFFF);
    issue_request(ACT_TICK, 32'd0, 32'd0);
    issue_request(ACT_SET_COUNTDOWN, 32'd0, 32'd0);
    issue_request(ACT_TICK, 32'd0, 32'd0);
    issue_request(ACT_TICK, 32'd0, 32'd0);

    // --- random mix: ticks and short adds dominate so slots keep turning over ---
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 25 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        issue_request(ACT_TICK, $urandom, $urandom);
      end else if (roll < 85) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) val = 32'd0;
        else if (roll < 90) val = $urandom_range(1, 12);
        else val = $urandom_range(13, 60);
        issue_request(ACT_ADD, val, $urandom);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 50) val = $urandom;
        else if (roll < 80) val = $urandom_range(1, 5);
        else val = 32'd0;
        if ($urandom_range(0, 1) == 0) issue_request(ACT_SET_COUNTDOWN, val, $urandom);
        else issue_request(ACT_START_DELAY, val, $urandom);
      end
    end

    // longest timeout last, since that slot never frees within the run
    issue_request(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(ACT_TICK, 32'd0, 32'd0);
    in_valid <= 1'b0;

    // let the pending count take in the last transaction, then drain and
    // give the block time to show any stray result
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (error_count == 0 && pending_count == 0) begin
      $display("tb_tick_timer_table passed");
    end else begin
      $display("tb_tick_timer_table failed");
    end
    $finish;
  end

endmodule
